// ----- rtl/fbsra_pkg.sv -----
// ----------------------------------------------------------------------------
// fbsra_pkg
// Widths, register indexes and shared types of the five-band RMS analyser.
// ----------------------------------------------------------------------------
package fbsra_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int COEF_W      = 25;
   localparam int COEF_SHIFT  = 24;
   localparam int STATE_W     = 26;
   localparam int BAND_W      = 27;
   localparam int MUL_W       = 28;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int SUM_W       = 61;
   localparam int RMS_W       = 24;
   localparam int NUM_FILTERS = 4;
   localparam int NUM_BANDS   = 5;

   // Square root of the quotient: radicand padded to an even width.
   localparam int RAD_W       = SUM_W + 1;
   localparam int ROOT_W      = RAD_W / 2;
   localparam int DIV_STEPS   = SUM_W;
   localparam int SQRT_STEPS  = ROOT_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = COEF_W;

   localparam logic [COEF_W-1:0] COEF_UNITY = COEF_W'(1) << COEF_SHIFT;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEREO_MIX      = 3'd0,
      CSR_COEF_BAND_ONE   = 3'd1,
      CSR_COEF_BAND_TWO   = 3'd2,
      CSR_COEF_BAND_THREE = 3'd3,
      CSR_COEF_BAND_FOUR  = 3'd4
   } csr_index_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [STATE_W-1:0]  lowpass_type;
   typedef logic signed [BAND_W-1:0]   band_type;
   typedef logic        [SUM_W-1:0]    sum_type;
   typedef logic        [RMS_W-1:0]    rms_type;

   typedef struct packed {
      logic    done;
      rms_type rms;
   } root_status_type;

endpackage

// ----- rtl/fbsra_if.sv -----
// ----------------------------------------------------------------------------
// fbsra_req_if / fbsra_rsp_if
// Valid/ready channels carrying sample pairs in and band RMS results out.
// ----------------------------------------------------------------------------
interface fbsra_req_if;
   logic                     valid;
   logic                     ready;
   fbsra_pkg::sample_type    left_sample;
   fbsra_pkg::sample_type    right_sample;
   logic                     block_end;

   modport source (output valid, output left_sample, output right_sample,
                   output block_end, input ready);
   modport sink   (input valid, input left_sample, input right_sample,
                   input block_end, output ready);
endinterface

interface fbsra_rsp_if;
   logic                valid;
   logic                ready;
   fbsra_pkg::rms_type  rms_lowest;
   fbsra_pkg::rms_type  rms_second;
   fbsra_pkg::rms_type  rms_third;
   fbsra_pkg::rms_type  rms_fourth;
   fbsra_pkg::rms_type  rms_highest;

   modport source (output valid, output rms_lowest, output rms_second,
                   output rms_third, output rms_fourth, output rms_highest,
                   input ready);
   modport sink   (input valid, input rms_lowest, input rms_second,
                   input rms_third, input rms_fourth, input rms_highest,
                   output ready);
endinterface

// ----- rtl/five_band_split_rms_analyser_core.sv -----
// ----------------------------------------------------------------------------
// five_band_split_rms_analyser_core
// Four one-pole low-pass filters split a mono signal into five bands whose
// RMS values are reported once per analysis block.
//
// Usage: write stereo_mix and the four Q0.24 coefficients through the csr_
// port while the block is idle. Send one sample pair per transaction on
// req_bus; set block_end on the last pair of a block. Only that transaction
// produces a result on rsp_bus, carrying the five band RMS values.
// An ordinary sample is taken in the idle state; the four filter products then
// run through the shared 28x28 multiplier, and the five bands are squared and
// accumulated on that same multiplier. The block is not ready during that
// time. A block-end sample adds the bit-serial divide and square root of
// each band.
// The result sits in an output register; the core keeps taking samples while
// it waits, and stalls only when a new result is due before the old one left.
// Reset clears the filter states, energy sums and sample count, sets stereo
// mixing on and all coefficients to zero.
// ----------------------------------------------------------------------------
module five_band_split_rms_analyser_core #(
   parameter int MAX_BLOCK = 4096
) (
   input  logic                                    clock,
   input  logic                                    reset,
   fbsra_req_if.sink                               req_bus,
   fbsra_rsp_if.source                             rsp_bus,
   input  logic                                    csr_write_enable,
   input  logic [fbsra_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [fbsra_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   localparam int CNT_W    = $clog2(MAX_BLOCK + 1);
   localparam int NF       = fbsra_pkg::NUM_FILTERS;
   localparam int NB       = fbsra_pkg::NUM_BANDS;
   localparam int STATE_W  = fbsra_pkg::STATE_W;
   localparam int MUL_W    = fbsra_pkg::MUL_W;
   localparam int PROD_W   = fbsra_pkg::PROD_W;
   localparam int SUM_W    = fbsra_pkg::SUM_W;
   localparam int SAMPLE_W = fbsra_pkg::SAMPLE_W;
   localparam int SHIFT    = fbsra_pkg::COEF_SHIFT;
   localparam int UPD_W    = PROD_W - SHIFT + 1;

   localparam logic [2:0] FILTER_LAST = 3'd4;
   localparam logic [2:0] SQUARE_LAST = 3'd5;
   localparam logic [2:0] BAND_LAST   = 3'(NB - 1);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_FILTER  = 5'b00010,
      ST_SQUARE  = 5'b00100,
      ST_ROOT    = 5'b01000,
      ST_PUBLISH = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [2:0]                    step_ff, step_in;
   logic                          stereo_mix_ff;
   logic [fbsra_pkg::COEF_W-1:0]  coef_ff [NF];
   fbsra_pkg::sample_type         mono_ff, mono_in;
   logic                          last_ff, last_in;
   fbsra_pkg::lowpass_type        lp_ff [NF];
   fbsra_pkg::lowpass_type        lp_in [NF];
   fbsra_pkg::lowpass_type        hold_ff, hold_in;
   fbsra_pkg::band_type           band_ff [NB];
   fbsra_pkg::band_type           band_in [NB];
   fbsra_pkg::sum_type            sum_ff [NB];
   fbsra_pkg::sum_type            sum_in [NB];
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          launched_ff, launched_in;
   fbsra_pkg::rms_type            res_ff [NB];
   fbsra_pkg::rms_type            res_in [NB];
   fbsra_pkg::rms_type            rsp_rms_ff [NB];
   fbsra_pkg::rms_type            rsp_rms_in [NB];
   logic                          rsp_valid_ff, rsp_valid_in;

   logic signed [SAMPLE_W:0]      pair_sum;
   logic [fbsra_pkg::COEF_W-1:0]  coef_sel;
   logic [fbsra_pkg::COEF_W-1:0]  coef_eff;
   logic signed [MUL_W-1:0]       mul_a;
   logic signed [MUL_W-1:0]       mul_b;
   logic signed [PROD_W-1:0]      product;
   logic signed [UPD_W-1:0]       upd_wide;
   fbsra_pkg::lowpass_type        lp_upd;
   logic [SUM_W:0]                acc_wide;
   fbsra_pkg::sum_type            acc_sat;
   logic                          root_start;
   fbsra_pkg::root_status_type    root_status;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_mix_ff <= 1'b1;
         for (int i = 0; i < NF; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_write_enable) begin
         case (fbsra_pkg::csr_index_type'(csr_index))
            fbsra_pkg::CSR_STEREO_MIX:      stereo_mix_ff <= csr_write_data[0];
            fbsra_pkg::CSR_COEF_BAND_ONE:   coef_ff[0]    <= csr_write_data;
            fbsra_pkg::CSR_COEF_BAND_TWO:   coef_ff[1]    <= csr_write_data;
            fbsra_pkg::CSR_COEF_BAND_THREE: coef_ff[2]    <= csr_write_data;
            fbsra_pkg::CSR_COEF_BAND_FOUR:  coef_ff[3]    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------ datapath
   assign pair_sum = {req_bus.left_sample[SAMPLE_W-1], req_bus.left_sample}
                   + {req_bus.right_sample[SAMPLE_W-1], req_bus.right_sample};

   assign coef_sel = coef_ff[step_ff[1:0]];
   assign coef_eff = (coef_sel > fbsra_pkg::COEF_UNITY) ? fbsra_pkg::COEF_UNITY : coef_sel;

   always_comb begin
      if (state_ff == ST_SQUARE) begin
         mul_a = {band_ff[0][fbsra_pkg::BAND_W-1], band_ff[0]};
         mul_b = {band_ff[0][fbsra_pkg::BAND_W-1], band_ff[0]};
      end else begin
         mul_a = {{(MUL_W-fbsra_pkg::COEF_W){1'b0}}, coef_eff};
         mul_b = {{(MUL_W-SAMPLE_W){mono_ff[SAMPLE_W-1]}}, mono_ff}
               - {{(MUL_W-STATE_W){lp_ff[0][STATE_W-1]}}, lp_ff[0]};
      end
   end

   fbsra_mult u_mult (
      .clock     (clock),
      .operand_a (mul_a),
      .operand_b (mul_b),
      .product   (product)
   );

   // Filter update: the arithmetic shift of the product floors toward minus
   // infinity; the clamp would only matter for coefficients above Q0.24 one, which coef_eff never passes.
   always_comb begin
      upd_wide = {{(UPD_W-STATE_W){hold_ff[STATE_W-1]}}, hold_ff}
               + {product[PROD_W-1], product[PROD_W-1:SHIFT]};
      if (upd_wide[UPD_W-1:STATE_W-1] == '0 || upd_wide[UPD_W-1:STATE_W-1] == '1) begin
         lp_upd = upd_wide[STATE_W-1:0];
      end else if (upd_wide[UPD_W-1]) begin
         lp_upd = {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         lp_upd = {1'b0, {(STATE_W-1){1'b1}}};
      end
   end

   // The square is never negative, so the product bits are taken unsigned.
   assign acc_wide = {1'b0, sum_ff[0]} + {{(SUM_W+1-PROD_W){1'b0}}, product};
   assign acc_sat  = acc_wide[SUM_W] ? '1 : acc_wide[SUM_W-1:0];

   fbsra_root #(
      .DIVISOR_W (CNT_W)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .dividend (sum_ff[0]),
      .divisor  (cnt_ff),
      .status   (root_status)
   );

   // ----------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      mono_in      = mono_ff;
      last_in      = last_ff;
      lp_in        = lp_ff;
      hold_in      = hold_ff;
      band_in      = band_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      launched_in  = launched_ff;
      res_in       = res_ff;
      rsp_rms_in   = rsp_rms_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      root_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               mono_in  = stereo_mix_ff ? pair_sum[SAMPLE_W:1] : req_bus.left_sample;
               last_in  = req_bus.block_end;
               step_in  = '0;
               state_in = ST_FILTER;
            end
         end
         ST_FILTER: begin
            // The filter states circulate as a ring; the head feeds the
            // multiplier while the previous product lands at the tail.
            hold_in = lp_ff[0];
            for (int i = 0; i < NF - 1; i++) begin
               lp_in[i] = lp_ff[i+1];
            end
            lp_in[NF-1] = lp_upd;
            step_in     = step_ff + 3'd1;
            if (step_ff == FILTER_LAST) begin
               band_in[0] = {lp_in[0][STATE_W-1], lp_in[0]};
               for (int i = 1; i < NF; i++) begin
                  band_in[i] = {lp_in[i][STATE_W-1], lp_in[i]}
                             - {lp_in[i-1][STATE_W-1], lp_in[i-1]};
               end
               band_in[NB-1] = {{(fbsra_pkg::BAND_W-SAMPLE_W){mono_ff[SAMPLE_W-1]}}, mono_ff}
                             - {lp_in[NF-1][STATE_W-1], lp_in[NF-1]};
               step_in  = '0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            for (int i = 0; i < NB - 1; i++) begin
               band_in[i] = band_ff[i+1];
            end
            if (step_ff != 3'd0) begin
               for (int i = 0; i < NB - 1; i++) begin
                  sum_in[i] = sum_ff[i+1];
               end
               sum_in[NB-1] = acc_sat;
            end
            step_in = step_ff + 3'd1;
            if (step_ff == SQUARE_LAST) begin
               if (cnt_ff < CNT_W'(MAX_BLOCK)) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               step_in  = '0;
               state_in = last_ff ? ST_ROOT : ST_IDLE;
            end
         end
         ST_ROOT: begin
            if (!launched_ff) begin
               root_start  = 1'b1;
               launched_in = 1'b1;
            end else if (root_status.done) begin
               // Each finished band leaves its sum cleared behind it.
               launched_in = 1'b0;
               for (int i = 0; i < NB - 1; i++) begin
                  sum_in[i] = sum_ff[i+1];
                  res_in[i] = res_ff[i+1];
               end
               sum_in[NB-1] = '0;
               res_in[NB-1] = root_status.rms;
               step_in      = step_ff + 3'd1;
               if (step_ff == BAND_LAST) begin
                  step_in  = '0;
                  state_in = ST_PUBLISH;
               end
            end
         end
         ST_PUBLISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_rms_in   = res_ff;
               rsp_valid_in = 1'b1;
               cnt_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NF; i++) begin
            lp_ff[i] <= '0;
         end
         for (int i = 0; i < NB; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
         lp_ff        <= lp_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      mono_ff    <= mono_in;
      last_ff    <= last_in;
      hold_ff    <= hold_in;
      band_ff    <= band_in;
      res_ff     <= res_in;
      rsp_rms_ff <= rsp_rms_in;
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.rms_lowest  = rsp_rms_ff[0];
   assign rsp_bus.rms_second  = rsp_rms_ff[1];
   assign rsp_bus.rms_third   = rsp_rms_ff[2];
   assign rsp_bus.rms_fourth  = rsp_rms_ff[3];
   assign rsp_bus.rms_highest = rsp_rms_ff[4];

   // ---------------------------------------------------------- assertions
   // All energy sums have been cleared by the time a result is published.
   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUBLISH |-> sum_ff[0] == '0 && sum_ff[1] == '0 && sum_ff[2] == '0
                                 && sum_ff[3] == '0 && sum_ff[4] == '0)
      else $error("energy sums not cleared before publish");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_BLOCK))
      else $error("sample count above the block limit");

   a_root_done_owned: assert property (@(posedge clock) disable iff (reset)
      root_status.done |-> state_ff == ST_ROOT && launched_ff)
      else $error("root result arrived with no band in flight");

   a_publish_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUBLISH && (!rsp_valid_ff || rsp_bus.ready)
      |=> rsp_valid_ff && cnt_ff == '0 && state_ff == ST_IDLE)
      else $error("result not loaded into the output register");

endmodule

// ----- rtl/fbsra_mult.sv -----
// ----------------------------------------------------------------------------
// fbsra_mult
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module fbsra_mult (
   input  logic                                clock,
   input  logic signed [fbsra_pkg::MUL_W-1:0]  operand_a,
   input  logic signed [fbsra_pkg::MUL_W-1:0]  operand_b,
   output logic signed [fbsra_pkg::PROD_W-1:0] product
);

   logic signed [fbsra_pkg::PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= operand_a * operand_b;
   end

   assign product = product_ff;

endmodule

// ----- rtl/fbsra_root.sv -----
// ----------------------------------------------------------------------------
// fbsra_root
// Bit-serial mean and square root: a restoring divide of the energy sum by
// the sample count, then a digit-by-digit root of the quotient, both on one
// shared compare-and-subtract datapath.
// ----------------------------------------------------------------------------
module fbsra_root #(
   parameter int DIVISOR_W = 13
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  fbsra_pkg::sum_type               dividend,
   input  logic [DIVISOR_W-1:0]             divisor,
   output fbsra_pkg::root_status_type       status
);

   localparam int SUB_W  = (DIVISOR_W + 1 > fbsra_pkg::ROOT_W + 4) ?
                           DIVISOR_W + 1 : fbsra_pkg::ROOT_W + 4;
   localparam int STEP_W = $clog2(fbsra_pkg::DIV_STEPS);
   localparam int SUM_W  = fbsra_pkg::SUM_W;
   localparam int RAD_W  = fbsra_pkg::RAD_W;
   localparam int ROOT_W = fbsra_pkg::ROOT_W;
   localparam int RMS_W  = fbsra_pkg::RMS_W;

   typedef enum logic [2:0] {
      R_IDLE   = 3'b001,
      R_DIVIDE = 3'b010,
      R_SQRT   = 3'b100
   } root_state_type;

   root_state_type        state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [RAD_W-1:0]      work_ff, work_in;
   logic [SUB_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic                  done_ff, done_in;
   fbsra_pkg::rms_type    rms_ff, rms_in;

   logic [SUB_W-1:0]      cand;
   logic [SUB_W-1:0]      operand;
   logic [SUB_W:0]        diff_wide;
   logic                  fits;

   // The one subtractor serves both the divide and the root steps.
   always_comb begin
      case (state_ff)
         R_DIVIDE: begin
            cand    = {rem_ff[SUB_W-2:0], work_ff[SUM_W-1]};
            operand = {{(SUB_W-DIVISOR_W){1'b0}}, divisor_ff};
         end
         R_SQRT: begin
            cand    = {rem_ff[SUB_W-3:0], work_ff[RAD_W-1:RAD_W-2]};
            operand = {{(SUB_W-ROOT_W-2){1'b0}}, root_ff, 2'b01};
         end
         default: begin
            cand    = '0;
            operand = '0;
         end
      endcase
      diff_wide = {1'b0, cand} - {1'b0, operand};
      fits      = ~diff_wide[SUB_W];
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      divisor_in = divisor_ff;
      done_in    = 1'b0;
      rms_in     = rms_ff;
      case (state_ff)
         R_IDLE: begin
            if (start) begin
               work_in    = {1'b0, dividend};
               divisor_in = divisor;
               rem_in     = '0;
               step_in    = '0;
               state_in   = R_DIVIDE;
            end
         end
         R_DIVIDE: begin
            rem_in  = fits ? diff_wide[SUB_W-1:0] : cand;
            work_in = {1'b0, work_ff[SUM_W-2:0], fits};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(fbsra_pkg::DIV_STEPS - 1)) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = R_SQRT;
            end
         end
         R_SQRT: begin
            rem_in  = fits ? diff_wide[SUB_W-1:0] : cand;
            root_in = {root_ff[ROOT_W-2:0], fits};
            work_in = {work_ff[RAD_W-3:0], 2'b00};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(fbsra_pkg::SQRT_STEPS - 1)) begin
               done_in  = 1'b1;
               rms_in   = (|root_in[ROOT_W-1:RMS_W]) ? '1 : root_in[RMS_W-1:0];
               state_in = R_IDLE;
            end
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      divisor_ff <= divisor_in;
      rms_ff     <= rms_in;
   end

   assign status.done = done_ff;
   assign status.rms  = rms_ff;

endmodule

// ----- dv/tb_five_band_split_rms_analyser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_five_band_split_rms_analyser_core
// Drives sample pairs into the five-band RMS analyser and predicts every band
// RMS result. The predictor keeps its own filter states and energy sums.
// Directed tests cover the reset defaults, mono selection and coefficient
// extremes. They also cover a long block of full-scale band swings. Random
// phases then use random block lengths and mostly random settings, with bursty
// input traffic in most phases and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb_five_band_split_rms_analyser_core;

   localparam int     BLOCK_LIMIT    = 4096;
   localparam int     RESULT_LATENCY = 5 * 94 + 1 + 12 + 40;
   localparam longint CYCLE_LIMIT    = 2_000_000;
   localparam int     LONG_BLOCK_LEN = 64;
   localparam int     RANDOM_PHASES  = 8;
   localparam int     PHASE_ITEMS    = 88;

   localparam longint LOWPASS_MAX = (longint'(1) << (fbsra_pkg::STATE_W - 1)) - 1;
   localparam longint LOWPASS_MIN = -(longint'(1) << (fbsra_pkg::STATE_W - 1));
   localparam longint unsigned ENERGY_LIMIT = (64'd1 << fbsra_pkg::SUM_W) - 1;
   localparam longint unsigned RMS_CEILING  = (64'd1 << fbsra_pkg::RMS_W) - 1;
   localparam fbsra_pkg::sample_type SAMPLE_MAX = fbsra_pkg::sample_type'(24'h7FFFFF);
   localparam fbsra_pkg::sample_type SAMPLE_MIN = fbsra_pkg::sample_type'(24'h800000);
   localparam logic [fbsra_pkg::COEF_W-1:0] COEF_ZERO     = '0;
   localparam logic [fbsra_pkg::COEF_W-1:0] COEF_ALL_ONES = '1;
   localparam logic [fbsra_pkg::COEF_W-1:0] COEF_UNITY    = fbsra_pkg::COEF_UNITY;

   // Band 0 is the lowest band, band 4 the highest.
   typedef logic [fbsra_pkg::NUM_BANDS-1:0][fbsra_pkg::RMS_W-1:0]    rms_set_type;
   typedef logic [fbsra_pkg::NUM_FILTERS-1:0][fbsra_pkg::COEF_W-1:0] coef_set_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_write_enable;
   logic [fbsra_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [fbsra_pkg::CSR_DATA_W-1:0]  csr_write_data;

   fbsra_req_if req_bus ();
   fbsra_rsp_if rsp_bus ();

   five_band_split_rms_analyser_core #(
      .MAX_BLOCK(BLOCK_LIMIT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   // Mirror of the analyser: settings, filter states, sums and sample count.
   bit                         mix_mirror;
   bit [fbsra_pkg::COEF_W-1:0] coef_mirror [fbsra_pkg::NUM_FILTERS];
   longint                     lowpass_mirror [fbsra_pkg::NUM_FILTERS];
   longint unsigned            energy_mirror [fbsra_pkg::NUM_BANDS];
   int                         block_count;
   rms_set_type                pending_rms [$];

   int     error_count = 0;
   longint cycle_count = 0;
   int     burst_left  = 0;
   int     gap_max     = 0;
   bit     req_held    = 0;
   string  band_label [fbsra_pkg::NUM_BANDS] =
      '{"lowest", "second", "third", "fourth", "highest"};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report_error(string msg);
      error_count++;
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
   endtask

   function automatic longint unsigned floor_root(longint unsigned value);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= value) root = trial;
      end
      return root;
   endfunction

   // Runs one sample pair through the filters and sums; on a block end it
   // queues the expected RMS values and clears the sums and the count.
   function automatic void split_and_accumulate(fbsra_pkg::sample_type left,
                                                fbsra_pkg::sample_type right,
                                                logic last);
      longint          mono;
      longint          coef;
      longint          band [fbsra_pkg::NUM_BANDS];
      longint unsigned mag;
      longint unsigned square;
      longint unsigned root;
      rms_set_type     rms;
      if (mix_mirror) mono = (longint'(left) + longint'(right)) >>> 1;
      else mono = longint'(left);
      for (int i = 0; i < fbsra_pkg::NUM_FILTERS; i++) begin
         coef = (coef_mirror[i] > COEF_UNITY) ? longint'(COEF_UNITY)
                                              : longint'(coef_mirror[i]);
         lowpass_mirror[i] += (coef * (mono - lowpass_mirror[i])) >>> fbsra_pkg::COEF_SHIFT;
         if (lowpass_mirror[i] > LOWPASS_MAX) lowpass_mirror[i] = LOWPASS_MAX;
         if (lowpass_mirror[i] < LOWPASS_MIN) lowpass_mirror[i] = LOWPASS_MIN;
      end
      band[0] = lowpass_mirror[0];
      for (int i = 1; i < fbsra_pkg::NUM_FILTERS; i++)
         band[i] = lowpass_mirror[i] - lowpass_mirror[i-1];
      band[fbsra_pkg::NUM_BANDS-1] = mono - lowpass_mirror[fbsra_pkg::NUM_FILTERS-1];
      for (int i = 0; i < fbsra_pkg::NUM_BANDS; i++) begin
         mag    = (band[i] < 0) ? -band[i] : band[i];
         square = mag * mag;
         if (square > ENERGY_LIMIT - energy_mirror[i]) energy_mirror[i] = ENERGY_LIMIT;
         else energy_mirror[i] += square;
      end
      if (block_count < BLOCK_LIMIT) block_count++;
      if (last) begin
         for (int i = 0; i < fbsra_pkg::NUM_BANDS; i++) begin
            root = floor_root(energy_mirror[i] / longint'(block_count));
            rms[i] = (root > RMS_CEILING) ? fbsra_pkg::RMS_W'(RMS_CEILING)
                                          : fbsra_pkg::RMS_W'(root);
            energy_mirror[i] = 0;
         end
         pending_rms.push_back(rms);
         block_count = 0;
      end
   endfunction

   // Writes every index of the register port, the unused ones included, one
   // per clock. Must be called at a clock edge while the block is idle.
   task automatic program_registers(bit mix, coef_set_type coefs);
      logic [fbsra_pkg::CSR_DATA_W-1:0] data;
      for (int k = 0; k < 2 ** fbsra_pkg::CSR_INDEX_W; k++) begin
         data = fbsra_pkg::CSR_DATA_W'($urandom);
         case (fbsra_pkg::CSR_INDEX_W'(k))
            fbsra_pkg::CSR_STEREO_MIX:      data[0] = mix;
            fbsra_pkg::CSR_COEF_BAND_ONE:   data = coefs[0];
            fbsra_pkg::CSR_COEF_BAND_TWO:   data = coefs[1];
            fbsra_pkg::CSR_COEF_BAND_THREE: data = coefs[2];
            fbsra_pkg::CSR_COEF_BAND_FOUR:  data = coefs[3];
            default: ;
         endcase
         csr_write_enable <= 1'b1;
         csr_index        <= fbsra_pkg::CSR_INDEX_W'(k);
         csr_write_data   <= data;
         @(posedge clock);
         case (fbsra_pkg::CSR_INDEX_W'(k))
            fbsra_pkg::CSR_STEREO_MIX:      mix_mirror = data[0];
            fbsra_pkg::CSR_COEF_BAND_ONE,
            fbsra_pkg::CSR_COEF_BAND_TWO,
            fbsra_pkg::CSR_COEF_BAND_THREE,
            fbsra_pkg::CSR_COEF_BAND_FOUR:
               coef_mirror[k - fbsra_pkg::CSR_COEF_BAND_ONE] = data;
            default: ;
         endcase
      end
      csr_write_enable <= 1'b0;
   endtask

   // Sends one sample pair and waits for the edge that accepted it. Valid stays
   // high while a burst goes on; after a burst it may drop for a random gap before the task returns.
   task automatic send_pair(fbsra_pkg::sample_type left, fbsra_pkg::sample_type right,
                            bit last);
      req_bus.valid        <= 1'b1;
      req_bus.left_sample  <= left;
      req_bus.right_sample <= right;
      req_bus.block_end    <= last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      split_and_accumulate(left, right, last);
      req_held = 1'b1;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 31);
         if (gap_max > 0 && $urandom_range(0, 3) != 0) begin
            req_bus.valid <= 1'b0;
            req_held = 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
   endtask

   // Drops valid, waits for every pending result and lets the core go quiet.
   task automatic wait_idle();
      if (req_held) begin
         req_bus.valid <= 1'b0;
         req_held = 1'b0;
      end
      while (pending_rms.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY) @(posedge clock);
   endtask

   function automatic fbsra_pkg::sample_type pick_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return fbsra_pkg::sample_type'(int'($urandom_range(0, 2000)) - 1000);
         default: return fbsra_pkg::sample_type'($urandom);
      endcase
   endfunction

   function automatic logic [fbsra_pkg::COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 7))
         0: return COEF_ZERO;
         1: return COEF_UNITY;
         2: return COEF_ALL_ONES;
         3: return COEF_UNITY + 1'b1;
         4, 5: return fbsra_pkg::COEF_W'($urandom_range(1, 1 << 20));
         default: return fbsra_pkg::COEF_W'($urandom);
      endcase
   endfunction

   task automatic send_random_block(int length);
      for (int n = 0; n < length; n++) send_pair(pick_sample(), pick_sample(), n == length - 1);
   endtask

   // Registers at their reset values: stereo mix on, every filter frozen at zero,
   // so only the highest band carries energy.
   task automatic test_reset_defaults();
      gap_max = 4;
      send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
      send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
      send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      send_pair(fbsra_pkg::sample_type'(-1), fbsra_pkg::sample_type'(0), 1'b1);
      // A one-sample block whose odd sum rounds toward minus infinity.
      send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
      wait_idle();
   endtask

   task automatic test_mono_select();
      program_registers(1'b0, {COEF_ALL_ONES, fbsra_pkg::COEF_W'(1),
                               fbsra_pkg::COEF_W'(1 << 23), COEF_UNITY});
      gap_max = 0;
      send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      send_pair(fbsra_pkg::sample_type'(0), SAMPLE_MAX, 1'b1);
      send_pair(SAMPLE_MIN, fbsra_pkg::sample_type'(0), 1'b1);
      wait_idle();
   endtask

   // Coefficients above one must act as exactly one.
   task automatic test_coefficient_extremes();
      program_registers(1'b1, {COEF_UNITY, COEF_UNITY + 1'b1, COEF_ALL_ONES, COEF_ZERO});
      gap_max = 6;
      send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
      send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
      send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
      send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
      send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_pair(fbsra_pkg::sample_type'(1), fbsra_pkg::sample_type'(2), 1'b1);
      wait_idle();
      program_registers(1'b1, {pick_coef(), pick_coef(), fbsra_pkg::COEF_W'(3),
                               fbsra_pkg::COEF_W'(1 << 12)});
      send_random_block(6);
      wait_idle();
   endtask

   // Parks the second and fourth filters at full scale, then drives the
   // opposite full scale for a long block. Four bands swing by almost 2^24,
   // so their energy sums grow large.
   task automatic test_long_block();
      gap_max = 2;
      program_registers(1'b0, {COEF_UNITY, COEF_ZERO, COEF_UNITY, COEF_ZERO});
      send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
      wait_idle();
      program_registers(1'b0, {COEF_ZERO, COEF_UNITY, COEF_ZERO, COEF_UNITY});
      for (int n = 0; n < LONG_BLOCK_LEN; n++)
         send_pair(SAMPLE_MIN, pick_sample(), n == LONG_BLOCK_LEN - 1);
      // The following block must start from a cleared count and cleared sums.
      send_random_block(3);
      wait_idle();
   endtask

   task automatic test_random_blocks();
      int           sent;
      int           length;
      bit           mix;
      coef_set_type coefs;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            mix   = 1'b1;
            coefs = {fbsra_pkg::NUM_FILTERS{COEF_ALL_ONES}};
         end else if (phase == 1) begin
            mix   = 1'b0;
            coefs = {fbsra_pkg::NUM_FILTERS{COEF_ZERO}};
         end else begin
            mix = $urandom_range(0, 1);
            for (int i = 0; i < fbsra_pkg::NUM_FILTERS; i++) coefs[i] = pick_coef();
         end
         program_registers(mix, coefs);
         gap_max = (phase % 3 == 0) ? 0 : $urandom_range(2, 12);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               7, 8: length = $urandom_range(9, 40);
               9:    length = $urandom_range(41, 300);
               default: length = $urandom_range(1, 8);
            endcase
            if (length > PHASE_ITEMS - sent) length = PHASE_ITEMS - sent;
            send_random_block(length);
            sent += length;
         end
         wait_idle();
      end
   endtask

   // The receiver follows a random ready pattern, reloaded from a fresh random draw;
   // some patterns are all ones so that long stretches run without stalls.
   initial begin
      logic [31:0] stall_pattern;
      stall_pattern = '1;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (cycle_count % 64 == 0)
            stall_pattern = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
         rsp_bus.ready <= stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
      end
   end

   always @(posedge clock) begin : check_band_rms
      rms_set_type got;
      rms_set_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = {rsp_bus.rms_highest, rsp_bus.rms_fourth, rsp_bus.rms_third,
                rsp_bus.rms_second, rsp_bus.rms_lowest};
         if (pending_rms.size() == 0) begin
            report_error($sformatf("result transaction with no block pending, lowest band %0d",
                                   got[0]));
         end else begin
            want = pending_rms.pop_front();
            for (int i = 0; i < fbsra_pkg::NUM_BANDS; i++)
               if (got[i] !== want[i])
                  report_error($sformatf("%s band RMS: got %0d, expected %0d",
                                         band_label[i], got[i], want[i]));
         end
      end
   end

   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.left_sample  <= '0;
      req_bus.right_sample <= '0;
      req_bus.block_end    <= 1'b0;
      csr_write_enable     <= 1'b0;
      csr_index            <= '0;
      csr_write_data       <= '0;
      mix_mirror  = 1'b1;
      block_count = 0;
      for (int i = 0; i < fbsra_pkg::NUM_FILTERS; i++) begin
         coef_mirror[i]    = '0;
         lowpass_mirror[i] = 0;
      end
      for (int i = 0; i < fbsra_pkg::NUM_BANDS; i++) energy_mirror[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_mono_select();
      test_coefficient_extremes();
      test_long_block();
      test_random_blocks();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
